/* rtl/scp_pkg.sv */
// ============================================================================
// scp_pkg: shared types and constants for the sine/cosine polynomial block
// Fixed-point constants, Horner coefficients, the stage bus type and the
// Q30 rounding helper used by the squaring, Horner and sine multiplies.
// ============================================================================
`default_nettype none

package scp_pkg;

    // Horner accumulator: signed Q30 with headroom for values up to about 4.0
    typedef logic signed [32:0] acc_t;

    // Data handed from one stage of the chain to the next
    typedef struct packed {
        logic               valid;
        logic               flip;
        logic signed [31:0] y;
        logic [31:0]        y2;
        acc_t               s_acc;
        acc_t               c_acc;
    } cell_bus_t;

    // Number of Horner cells in the chain
    localparam int NUM_CELLS = 5;

    // Range reduction constants
    localparam logic [31:0]        INV_TWO_PI  = 32'd683565275;    // 1/(2*pi), Q32
    localparam logic signed [39:0] TWO_PI_Q30  = 40'sd6746518852;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam acc_t               ONE_Q30     = 33'sd1073741824;

    // Leading coefficients that seed the accumulators
    localparam acc_t S5 = -33'sd26;
    localparam acc_t C5 = -33'sd280;

    // Coefficient added by each cell, first cell first
    localparam acc_t S_COEF [NUM_CELLS] = '{
        33'sd2956, -33'sd213040, 33'sd8947846, -33'sd178956974, 33'sd1073741824
    };
    localparam acc_t C_COEF [NUM_CELLS] = '{
        33'sd26586, -33'sd1491253, 33'sd44739212, -33'sd536870912, 33'sd1073741824
    };

    // Round a product magnitude from Q60 to Q30, half away from zero, and
    // apply the sign
    function automatic logic signed [34:0] round_q30(input logic [63:0] mag,
                                                     input logic neg);
        logic [63:0]        sum;
        logic signed [34:0] r;
        sum = mag + (64'd1 << 29);
        r   = {1'b0, sum[63:30]};
        return neg ? -r : r;
    endfunction

endpackage

`default_nettype wire

/* rtl/scp_reduce.sv */
// ============================================================================
// scp_reduce: angle range reduction and squaring
// Removes whole turns, reflects into [-pi/2, pi/2], squares the remainder and
// seeds the Horner accumulators. Five register stages.
// ============================================================================
`default_nettype none

module scp_reduce (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] angle,
    output scp_pkg::cell_bus_t      bus_out
);

    // Stage valid bits
    logic [4:0] valid_reg;

    // Stage 1: turn count
    logic [31:0]        ang_mag;
    logic [63:0]        turn_prod;
    logic [63:0]        turn_sum;
    logic [5:0]         turns_next;
    logic signed [5:0]  turns_reg;
    logic signed [31:0] ang1_reg;

    // Stage 2: remainder
    logic signed [39:0] ang_q30;
    logic signed [39:0] turn_q30;
    logic signed [39:0] yraw_full;
    logic signed [33:0] yraw_reg;

    // Stage 3: reflection
    logic signed [33:0] y3_next;
    logic               flip3_next;
    logic signed [31:0] y3_reg;
    logic               flip3_reg;

    // Stage 4: square
    logic [31:0]        y_mag;
    logic [63:0]        ysq_reg;
    logic signed [31:0] y4_reg;
    logic               flip4_reg;

    // Stage 5: rounded square
    logic signed [34:0] y2_full;
    logic [31:0]        y2_reg;
    logic signed [31:0] y5_reg;
    logic               flip5_reg;

    // Count whole turns, rounded half away from zero
    always_comb
    begin
        ang_mag    = angle[31] ? (32'd0 - angle) : angle;
        turn_prod  = {32'd0, ang_mag} * {32'd0, scp_pkg::INV_TWO_PI};
        turn_sum   = turn_prod + (64'd1 << 55);
        turns_next = angle[31] ? (6'd0 - {1'b0, turn_sum[60:56]})
                               : {1'b0, turn_sum[60:56]};
    end

    // Subtract the turns in Q30
    always_comb
    begin
        ang_q30   = {{2{ang1_reg[31]}}, ang1_reg, 6'd0};
        turn_q30  = 40'(turns_reg) * scp_pkg::TWO_PI_Q30;
        yraw_full = ang_q30 - turn_q30;
    end

    // Reflect remainders beyond a quarter turn
    always_comb
    begin
        y3_next    = yraw_reg;
        flip3_next = 1'b0;
        if (yraw_reg > scp_pkg::HALF_PI_Q30)
        begin
            y3_next    = scp_pkg::PI_Q30 - yraw_reg;
            flip3_next = 1'b1;
        end
        else if (yraw_reg < -scp_pkg::HALF_PI_Q30)
        begin
            y3_next    = -scp_pkg::PI_Q30 - yraw_reg;
            flip3_next = 1'b1;
        end
    end

    // Square magnitude and its rounding
    assign y_mag   = y3_reg[31] ? (32'd0 - y3_reg) : y3_reg;
    assign y2_full = scp_pkg::round_q30(ysq_reg, 1'b0);

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        turns_reg <= turns_next;
        ang1_reg  <= angle;
        yraw_reg  <= yraw_full[33:0];
        y3_reg    <= y3_next[31:0];
        flip3_reg <= flip3_next;
        ysq_reg   <= {32'd0, y_mag} * {32'd0, y_mag};
        y4_reg    <= y3_reg;
        flip4_reg <= flip3_reg;
        y2_reg    <= y2_full[31:0];
        y5_reg    <= y4_reg;
        flip5_reg <= flip4_reg;
    end

    // Seed the accumulators with the leading coefficients
    always_comb
    begin
        bus_out.valid = valid_reg[4];
        bus_out.flip  = flip5_reg;
        bus_out.y     = y5_reg;
        bus_out.y2    = y2_reg;
        bus_out.s_acc = scp_pkg::S5;
        bus_out.c_acc = scp_pkg::C5;
    end

endmodule

`default_nettype wire

/* rtl/scp_cell.sv */
// ============================================================================
// scp_cell: one Horner step for sine and cosine
// Multiplies both accumulators by y^2, rounds to Q30 and adds the cell's
// coefficients. Two register stages.
// ============================================================================
`default_nettype none

module scp_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scp_pkg::cell_bus_t bus_in,
    input  wire scp_pkg::acc_t      s_coef,
    input  wire scp_pkg::acc_t      c_coef,
    output scp_pkg::cell_bus_t      bus_out
);

    // Multiply stage
    scp_pkg::acc_t      s_neg_acc;
    scp_pkg::acc_t      c_neg_acc;
    logic [31:0]        s_mag;
    logic [31:0]        c_mag;
    logic               va_reg;
    logic               flip_a_reg;
    logic signed [31:0] y_a_reg;
    logic [31:0]        y2_a_reg;
    logic [63:0]        s_pm_reg;
    logic               s_neg_reg;
    logic [63:0]        c_pm_reg;
    logic               c_neg_reg;

    // Add stage
    logic signed [34:0] s_sum;
    logic signed [34:0] c_sum;
    logic               vb_reg;
    logic               flip_b_reg;
    logic signed [31:0] y_b_reg;
    logic [31:0]        y2_b_reg;
    scp_pkg::acc_t      s_acc_reg;
    scp_pkg::acc_t      c_acc_reg;

    // Take accumulator magnitudes; y^2 is never negative
    always_comb
    begin
        s_neg_acc = -bus_in.s_acc;
        c_neg_acc = -bus_in.c_acc;
        s_mag     = bus_in.s_acc[32] ? s_neg_acc[31:0] : bus_in.s_acc[31:0];
        c_mag     = bus_in.c_acc[32] ? c_neg_acc[31:0] : bus_in.c_acc[31:0];
    end

    // Round and add the coefficients
    always_comb
    begin
        s_sum = scp_pkg::round_q30(s_pm_reg, s_neg_reg) + 35'(s_coef);
        c_sum = scp_pkg::round_q30(c_pm_reg, c_neg_reg) + 35'(c_coef);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= bus_in.valid;
            vb_reg <= va_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        flip_a_reg <= bus_in.flip;
        y_a_reg    <= bus_in.y;
        y2_a_reg   <= bus_in.y2;
        s_pm_reg   <= {32'd0, s_mag} * {32'd0, bus_in.y2};
        s_neg_reg  <= bus_in.s_acc[32];
        c_pm_reg   <= {32'd0, c_mag} * {32'd0, bus_in.y2};
        c_neg_reg  <= bus_in.c_acc[32];
        flip_b_reg <= flip_a_reg;
        y_b_reg    <= y_a_reg;
        y2_b_reg   <= y2_a_reg;
        s_acc_reg  <= s_sum[32:0];
        c_acc_reg  <= c_sum[32:0];
    end

    // Hand the step to the next cell
    always_comb
    begin
        bus_out.valid = vb_reg;
        bus_out.flip  = flip_b_reg;
        bus_out.y     = y_b_reg;
        bus_out.y2    = y2_b_reg;
        bus_out.s_acc = s_acc_reg;
        bus_out.c_acc = c_acc_reg;
    end

endmodule

`default_nettype wire

/* rtl/scp_finish.sv */
// ============================================================================
// scp_finish: final sine multiply, cosine sign and saturation
// Multiplies the sine series by y, negates reflected cosines and clamps both
// to +-1.0 in Q1.30. Three register stages.
// ============================================================================
`default_nettype none

module scp_finish (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scp_pkg::cell_bus_t bus_in,
    output logic                    done,
    output logic signed [31:0]      sine_value,
    output logic signed [31:0]      cosine_value
);

    // Stage 1: sine product, cosine sign
    scp_pkg::acc_t      s_neg_acc;
    logic [31:0]        s_mag;
    logic [31:0]        y_mag;
    scp_pkg::acc_t      c1_next;
    logic               v1_reg;
    logic [63:0]        s_pm_reg;
    logic               s_neg_reg;
    scp_pkg::acc_t      c1_reg;

    // Stage 2: rounded sine
    logic signed [34:0] s_round;
    logic               v2_reg;
    scp_pkg::acc_t      s2_reg;
    scp_pkg::acc_t      c2_reg;

    // Stage 3: saturated outputs
    scp_pkg::acc_t      s_sat;
    scp_pkg::acc_t      c_sat;
    logic               done_reg;
    logic signed [31:0] sine_reg;
    logic signed [31:0] cosine_reg;

    // Form magnitudes and the reflected cosine
    always_comb
    begin
        s_neg_acc = -bus_in.s_acc;
        s_mag     = bus_in.s_acc[32] ? s_neg_acc[31:0] : bus_in.s_acc[31:0];
        y_mag     = bus_in.y[31] ? (32'd0 - bus_in.y) : bus_in.y;
        c1_next   = bus_in.flip ? -bus_in.c_acc : bus_in.c_acc;
    end

    assign s_round = scp_pkg::round_q30(s_pm_reg, s_neg_reg);

    // Clamp to +-1.0
    always_comb
    begin
        s_sat = s2_reg;
        if (s2_reg > scp_pkg::ONE_Q30)
        begin
            s_sat = scp_pkg::ONE_Q30;
        end
        else if (s2_reg < -scp_pkg::ONE_Q30)
        begin
            s_sat = -scp_pkg::ONE_Q30;
        end
        c_sat = c2_reg;
        if (c2_reg > scp_pkg::ONE_Q30)
        begin
            c_sat = scp_pkg::ONE_Q30;
        end
        else if (c2_reg < -scp_pkg::ONE_Q30)
        begin
            c_sat = -scp_pkg::ONE_Q30;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= bus_in.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        s_pm_reg   <= {32'd0, s_mag} * {32'd0, y_mag};
        s_neg_reg  <= bus_in.s_acc[32] ^ bus_in.y[31];
        c1_reg     <= c1_next;
        s2_reg     <= s_round[32:0];
        c2_reg     <= c1_reg;
        sine_reg   <= s_sat[31:0];
        cosine_reg <= c_sat[31:0];
    end

    assign done         = done_reg;
    assign sine_value   = sine_reg;
    assign cosine_value = cosine_reg;

endmodule

`default_nettype wire

/* rtl/sine_cosine_polynomial.sv */
// ============================================================================
// sine_cosine_polynomial: pipelined sine and cosine of a Q7.24 angle
// Range reduction to [-pi/2, pi/2], then a chain of Horner cells evaluating
// odd (sine) and even (cosine) polynomials, then saturation to +-1.0.
// ============================================================================
//
//  Channel   Ports                          Transfer
//  --------  -----------------------------  ---------------------------
//  command   start, busy, angle             edge with start high, busy low
//  result    done, sine_value, cosine_value edge ending the cycle done is high
//
//  One angle enters every cycle; busy is held low.
//  Each result passes through 5 reduction stages, 5 Horner cells of
//  2 stages each and 3 finishing stages after its command transfer.
//  Reset clears only the stage valid bits; no item is in flight afterward.
//  The receiver cannot stall, so results stream out in input order.
// ============================================================================
`default_nettype none

module sine_cosine_polynomial (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] angle,
    output logic                    busy,
    output logic                    done,
    output logic signed [31:0]      sine_value,
    output logic signed [31:0]      cosine_value
);

    localparam int LATENCY = 18;

    scp_pkg::cell_bus_t chain [scp_pkg::NUM_CELLS + 1];

    // The pipeline accepts a command every cycle
    assign busy = 1'b0;

    // Reduce the angle and seed the accumulators
    scp_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .angle    (angle),
        .bus_out  (chain[0])
    );

    // Horner cells, highest order first
    for (genvar g = 0; g < scp_pkg::NUM_CELLS; g++)
    begin : g_cell
        scp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (chain[g]),
            .s_coef  (scp_pkg::S_COEF[g]),
            .c_coef  (scp_pkg::C_COEF[g]),
            .bus_out (chain[g + 1])
        );
    end

    // Final sine multiply and saturation
    scp_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .bus_in       (chain[scp_pkg::NUM_CELLS]),
        .done         (done),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

    // Every command transfer yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after command transfer");

    // Every result traces back to a command transfer
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching command");

    // Saturated outputs stay within +-1.0
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sine_value <= 32'sd1073741824 && sine_value >= -32'sd1073741824))
        else $error("sine out of range");

    a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cosine_value <= 32'sd1073741824 && cosine_value >= -32'sd1073741824))
        else $error("cosine out of range");

endmodule

`default_nettype wire

/* verif/sc_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine result monitor
// Watches the command and result channels of sine_cosine_polynomial, predicts
// the sine and cosine of every angle transfer in Q1.30 and compares each
// result, in order, against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module sc_monitor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] angle,
    input  logic               done,
    input  logic signed [31:0] sine_value,
    input  logic signed [31:0] cosine_value,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } sin_cos_t;

    // Range reduction constants, Q32 and Q30
    localparam longint RECIP_TURN = 64'sd683565275;
    localparam longint TURN_Q30   = 64'sd6746518852;
    localparam longint HALFTURN   = 64'sd3373259426;
    localparam longint QUARTER    = 64'sd1686629713;
    localparam longint UNIT_Q30   = 64'sd1073741824;

    // Horner coefficients, highest order first
    localparam longint SIN_K5 = -64'sd26;
    localparam longint SIN_K4 = 64'sd2956;
    localparam longint SIN_K3 = -64'sd213040;
    localparam longint SIN_K2 = 64'sd8947846;
    localparam longint SIN_K1 = -64'sd178956974;
    localparam longint COS_K5 = -64'sd280;
    localparam longint COS_K4 = 64'sd26586;
    localparam longint COS_K3 = -64'sd1491253;
    localparam longint COS_K2 = 64'sd44739212;
    localparam longint COS_K1 = -64'sd536870912;

    sin_cos_t expected_q[$];

    function automatic bit [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Q30 times Q30, rounded to Q30 half away from zero
    function automatic longint mul_q30(input longint x, input longint z);
        bit        neg;
        bit [63:0] m;
        longint    r;
        neg = (x < 0) != (z < 0);
        m   = magnitude(x) * magnitude(z);
        r   = longint'((m + (64'd1 << 29)) >> 30);
        return neg ? -r : r;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT_Q30)
            return UNIT_Q30;
        if (v < -UNIT_Q30)
            return -UNIT_Q30;
        return v;
    endfunction

    function automatic sin_cos_t predict_sin_cos(input logic signed [31:0] ang);
        longint   a;
        longint   prod;
        longint   turns;
        longint   y;
        longint   y2;
        longint   s;
        longint   c;
        bit       flip;
        sin_cos_t res;
        a    = ang;
        prod = a * RECIP_TURN;
        // Round the turn count half away from zero
        turns = longint'((magnitude(prod) + (64'd1 << 55)) >> 56);
        if (prod < 0)
            turns = -turns;
        y    = a * 64 - turns * TURN_Q30;
        flip = 1'b0;
        // Fold the remainder into [-pi/2, pi/2]
        if (y > QUARTER)
        begin
            y    = HALFTURN - y;
            flip = 1'b1;
        end
        else if (y < -QUARTER)
        begin
            y    = -HALFTURN - y;
            flip = 1'b1;
        end
        y2 = mul_q30(y, y);
        s  = SIN_K5;
        s  = mul_q30(s, y2) + SIN_K4;
        s  = mul_q30(s, y2) + SIN_K3;
        s  = mul_q30(s, y2) + SIN_K2;
        s  = mul_q30(s, y2) + SIN_K1;
        s  = mul_q30(s, y2) + UNIT_Q30;
        s  = mul_q30(s, y);
        c  = COS_K5;
        c  = mul_q30(c, y2) + COS_K4;
        c  = mul_q30(c, y2) + COS_K3;
        c  = mul_q30(c, y2) + COS_K2;
        c  = mul_q30(c, y2) + COS_K1;
        c  = mul_q30(c, y2) + UNIT_Q30;
        if (flip)
            c = -c;
        res.sine   = 32'(clamp_unit(s));
        res.cosine = 32'(clamp_unit(c));
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Queue a prediction per command transfer, retire one per result
    always @(posedge clk)
    begin
        sin_cos_t want;
        if (rst_n)
        begin
            if (start && !busy)
                expected_q.push_back(predict_sin_cos(angle));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no angle outstanding: sine %0d cosine %0d",
                           sine_value, cosine_value);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (sine_value !== want.sine)
                    begin
                        $error("sine_value mismatch: expected %0d, actual %0d",
                               want.sine, sine_value);
                        fail_count = fail_count + 1;
                    end
                    if (cosine_value !== want.cosine)
                    begin
                        $error("cosine_value mismatch: expected %0d, actual %0d",
                               want.cosine, cosine_value);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine polynomial testbench
// Feeds directed angles (range extremes, quarter and half turns, odd
// multiples of pi near the rounding boundary) and then random angles in
// bursts with random gaps; the monitor predicts and checks every result.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_RANDOM  = 900;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 40;
    localparam int QUARTER_Q24 = 26353589;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic signed [31:0] angle;
    logic               busy;
    logic               done;
    logic signed [31:0] sine_value;
    logic signed [31:0] cosine_value;
    int                 fail_count;
    int                 pending;

    sine_cosine_polynomial uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .angle        (angle),
        .busy         (busy),
        .done         (done),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

    sc_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .angle        (angle),
        .done         (done),
        .sine_value   (sine_value),
        .cosine_value (cosine_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold the angle on the port until its transfer happens
    task automatic send_angle(input logic [31:0] a);
        start <= 1'b1;
        angle <= a;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Mix of full-range, moderate, near quarter-turn and tiny angles
    function automatic logic [31:0] pick_angle();
        int     mode;
        longint v;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return $urandom;
        if (mode < 7)
            return 32'(longint'($urandom_range(0, 32'h1000_0000)) - 64'sd134217728);
        if (mode < 9) begin
            v = longint'($signed($urandom_range(0, 162))) - 81;
            v = v * QUARTER_Q24 + longint'($urandom_range(0, 1024)) - 512;
            return 32'(v);
        end
        return 32'(longint'($urandom_range(0, 8192)) - 4096);
    endfunction

    // Directed angles: range ends, quarter and half turns, full turns
    logic [31:0] directed [] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'd26353588, 32'd26353589, -32'sd26353588, -32'sd26353589,
        32'd52707178, 32'd52707179, 32'd52707180, -32'sd52707179,
        32'd105414357, -32'sd105414357, 32'd158121536, -32'sd158121536,
        32'd2055575993, -32'sd2055575993, 32'h0100_0000, 32'h0000_0040,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    // Watchdog: end the run if nothing transfers for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int burst_left;
        rst_n <= 1'b0;
        start <= 1'b0;
        angle <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed angles, back to back
        foreach (directed[i])
            send_angle(directed[i]);

        // Random angles in bursts separated by idle gaps
        burst_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                          : $urandom_range(1, 20);
                start <= 1'b0;
                angle <= $urandom;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            send_angle(pick_angle());
            burst_left = burst_left - 1;
        end
        start <= 1'b0;

        // Drain the pipeline
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sine_cosine_polynomial.f */
rtl/scp_pkg.sv
rtl/scp_reduce.sv
rtl/scp_cell.sv
rtl/scp_finish.sv
rtl/sine_cosine_polynomial.sv
verif/sc_monitor.sv
verif/tb.sv
